// ===== rtl/cwc_pkg.sv =====
`default_nettype none
package cwc_pkg;

    localparam int WIN_W    = 16;
    localparam int SEQ_W    = 32;
    localparam int THRESH_W = 27;
    localparam int ZCNT_W   = 2;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIN_W-1:0]    WINDOW_MAX      = 16'hFFFF;
    localparam logic [WIN_W-1:0]    GROWTH_MAX      = 16'hFFFF;
    localparam logic [WIN_W-1:0]    INFLIGHT_MAX    = 16'hFFFF;
    localparam logic [WIN_W-1:0]    START_WINDOW    = 16'd1;
    localparam logic [WIN_W-1:0]    INIT_PEER_WIN   = 16'd8;
    localparam logic [THRESH_W-1:0] THRESH_RESET    = 27'd99999999;
    localparam logic [ZCNT_W-1:0]   ZERO_ACK_LIMIT  = 2'd3;
    localparam logic [SEQ_W-1:0]    SEQ_RESET       = 32'd1;
    localparam logic [SEQ_W-1:0]    EXP_ACK_RESET   = 32'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PEER_WIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENDER_MODE   = 1'b1;

    typedef enum logic [1:0] {
        REQ_ACK      = 2'd0,
        REQ_TIMEOUT  = 2'd1,
        REQ_SEND     = 2'd2,
        REQ_PEER_END = 2'd3
    } t_req;

    typedef struct packed {
        t_req              kind;
        logic [SEQ_W-1:0]  ack;
        logic              zero_ack;
        logic [WIN_W-1:0]  peer;
        logic              data_ready;
        logic              data_is_end;
    } t_cmd;

    typedef struct packed {
        logic              grant;
        logic [SEQ_W-1:0]  grant_seq;
        logic              ack_accepted;
        logic [WIN_W-1:0]  send_window;
        logic [WIN_W-1:0]  congestion_window;
        logic [WIN_W-1:0]  in_flight_count;
    } t_result;

    // queue head handshake toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage
`default_nettype wire

// ===== rtl/cwc_front.sv =====
`default_nettype none
module cwc_front (
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [cwc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [cwc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                           i_q_full,
    output      logic                           o_push,
    output      cwc_pkg::t_cmd                  o_cmd
);

    always_comb begin
        s_axis_tready     = !i_q_full;
        o_push            = s_axis_tvalid && !i_q_full;
        o_cmd.kind        = cwc_pkg::t_req'(s_axis_tuser);
        o_cmd.ack         = s_axis_tdata[31:0];
        o_cmd.zero_ack    = (s_axis_tdata[31:0] == '0);
        o_cmd.peer        = s_axis_tdata[47:32];
        o_cmd.data_ready  = s_axis_tdata[48];
        o_cmd.data_is_end = s_axis_tdata[49];
    end

endmodule
`default_nettype wire

// ===== rtl/cwc_queue.sv =====
`default_nettype none
module cwc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cwc_pkg::t_cmd  i_cmd,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      cwc_pkg::t_head o_head
);

    cwc_pkg::t_cmd r_mem [cwc_pkg::QUEUE_DEPTH];

    logic [cwc_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [cwc_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [cwc_pkg::QCNT_W-1:0] r_count, n_count;
    logic                       do_push;
    logic                       do_pop;

    always_comb begin
        o_full        = (r_count == cwc_pkg::QCNT_W'(cwc_pkg::QUEUE_DEPTH));
        do_push       = i_push && !o_full;
        do_pop        = i_pop && (r_count != '0);
        o_head.valid  = (r_count != '0);
        o_head.cmd    = r_mem[r_rd_ptr];
        n_wr_ptr      = r_wr_ptr;
        n_rd_ptr      = r_rd_ptr;
        n_count       = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == cwc_pkg::QPTR_W'(cwc_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == cwc_pkg::QPTR_W'(cwc_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cwc_back.sv =====
`default_nettype none
module cwc_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire cwc_pkg::t_head                  i_head,
    output      logic                            o_pop,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [cwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cwc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output      logic                            o_res_valid,
    input  wire logic                            i_res_ready,
    output      cwc_pkg::t_result                o_res
);

    logic [cwc_pkg::WIN_W-1:0]    r_cw, n_cw;
    logic [cwc_pkg::WIN_W-1:0]    r_uw, n_uw;
    logic [cwc_pkg::THRESH_W-1:0] r_ssth, n_ssth;
    logic [cwc_pkg::WIN_W-1:0]    r_gc, n_gc;
    logic [cwc_pkg::WIN_W-1:0]    r_pw, n_pw;
    logic [cwc_pkg::SEQ_W-1:0]    r_nss, n_nss;
    logic [cwc_pkg::SEQ_W-1:0]    r_eack, n_eack;
    logic [cwc_pkg::WIN_W-1:0]    r_inf, n_inf;
    logic [cwc_pkg::ZCNT_W-1:0]   r_zc, n_zc;
    logic                         r_lend, n_lend;
    logic                         r_pend, n_pend;
    logic                         r_mode, n_mode;
    logic                         r_out_valid, n_out_valid;
    cwc_pkg::t_result             r_out, n_out;

    cwc_pkg::t_cmd                cmd;
    logic                         fire;
    logic                         match;
    logic [cwc_pkg::THRESH_W-1:0] g_ssth;
    logic                         g_above;
    logic [cwc_pkg::WIN_W-1:0]    gc_inc;
    logic [cwc_pkg::WIN_W-1:0]    cw_inc;
    logic                         g_step;
    logic [cwc_pkg::WIN_W-1:0]    g_cw;
    logic [cwc_pkg::WIN_W-1:0]    g_gc;
    logic [cwc_pkg::WIN_W-1:0]    g_pw;
    logic [cwc_pkg::WIN_W-1:0]    g_min;
    logic [cwc_pkg::WIN_W-1:0]    g_uw;
    logic [cwc_pkg::WIN_W-1:0]    z_min;
    logic                         grant;
    logic [cwc_pkg::SEQ_W-1:0]    seq;
    logic                         accepted;

    // window growth, shared by ack, timeout and peer end
    always_comb begin
        cmd     = i_head.cmd;
        g_ssth  = (cmd.kind == cwc_pkg::REQ_TIMEOUT) ? (r_ssth >> 1) : r_ssth;
        g_above = ({{(cwc_pkg::THRESH_W - cwc_pkg::WIN_W){1'b0}}, r_uw} > g_ssth);
        gc_inc  = (r_gc != cwc_pkg::GROWTH_MAX) ? r_gc + 1'b1 : r_gc;
        cw_inc  = (r_cw < cwc_pkg::WINDOW_MAX) ? r_cw + 1'b1 : r_cw;
        g_step  = (gc_inc >= r_uw);
        if (g_above) begin
            g_gc = g_step ? '0 : gc_inc;
            g_cw = g_step ? cw_inc : r_cw;
            g_pw = r_pw;
        end else begin
            g_gc = r_gc;
            g_cw = cw_inc;
            g_pw = (cmd.kind == cwc_pkg::REQ_ACK) ? cmd.peer : r_pw;
        end
        g_min = (g_pw < g_cw) ? g_pw : g_cw;
        g_uw  = (g_min < cwc_pkg::WINDOW_MAX) ? g_min : cwc_pkg::WINDOW_MAX;
    end

    always_comb begin
        n_cw        = r_cw;
        n_uw        = r_uw;
        n_ssth      = r_ssth;
        n_gc        = r_gc;
        n_pw        = r_pw;
        n_nss       = r_nss;
        n_eack      = r_eack;
        n_inf       = r_inf;
        n_zc        = r_zc;
        n_lend      = r_lend;
        n_pend      = r_pend;
        n_mode      = r_mode;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        grant       = 1'b0;
        seq         = '0;
        accepted    = 1'b0;
        z_min       = '0;
        match       = (cmd.ack == r_eack);

        fire  = i_head.valid && (!r_out_valid || i_res_ready);
        o_pop = fire;
        o_cfg_ready = 1'b1;

        if (fire) begin
            case (cmd.kind)
                cwc_pkg::REQ_ACK: begin
                    if (match) begin
                        accepted = 1'b1;
                        if (r_mode) begin
                            n_cw = g_cw;
                            n_uw = g_uw;
                            n_gc = g_gc;
                            n_pw = g_pw;
                        end
                        n_eack = cmd.ack + 1'b1;
                        n_inf  = (r_inf != '0) ? r_inf - 1'b1 : r_inf;
                        // retry a send with the freed slot
                        if (!r_lend && (n_inf < n_uw) && cmd.data_ready) begin
                            grant = 1'b1;
                            seq   = r_nss;
                            n_nss = r_nss + 1'b1;
                            if (cmd.data_is_end) begin
                                n_lend = 1'b1;
                            end
                            if (n_inf != cwc_pkg::INFLIGHT_MAX) begin
                                n_inf = n_inf + 1'b1;
                            end
                        end
                        n_zc = '0;
                    end
                    if (cmd.zero_ack) begin
                        n_zc = n_zc + 1'b1;
                        if (n_zc == cwc_pkg::ZERO_ACK_LIMIT) begin
                            n_cw   = n_cw >> 1;
                            n_zc   = '0;
                            n_ssth = r_ssth >> 1;
                        end
                        z_min = (n_pw < n_cw) ? n_pw : n_cw;
                        n_uw  = (z_min < cwc_pkg::WINDOW_MAX) ? z_min : cwc_pkg::WINDOW_MAX;
                    end
                end
                cwc_pkg::REQ_TIMEOUT: begin
                    n_ssth = g_ssth;
                    n_cw   = g_cw;
                    n_uw   = g_uw;
                    n_gc   = g_gc;
                    n_pw   = g_pw;
                end
                cwc_pkg::REQ_SEND: begin
                    if (!r_lend && (r_inf < r_uw) && cmd.data_ready) begin
                        grant = 1'b1;
                        seq   = r_nss;
                        n_nss = r_nss + 1'b1;
                        if (cmd.data_is_end) begin
                            n_lend = 1'b1;
                        end
                        if (r_inf != cwc_pkg::INFLIGHT_MAX) begin
                            n_inf = r_inf + 1'b1;
                        end
                    end
                end
                cwc_pkg::REQ_PEER_END: begin
                    if (!r_pend) begin
                        n_pend = 1'b1;
                        if (r_mode) begin
                            n_gc = g_gc;
                            n_pw = g_pw;
                            n_cw = (g_cw != '0) ? g_cw - 1'b1 : g_cw;
                            n_uw = (g_uw != '0) ? g_uw - 1'b1 : g_uw;
                        end
                    end
                end
                default: begin
                    n_pend = r_pend;
                end
            endcase
            n_out.grant             = grant;
            n_out.grant_seq         = seq;
            n_out.ack_accepted      = accepted;
            n_out.send_window       = n_uw;
            n_out.congestion_window = n_cw;
            n_out.in_flight_count   = n_inf;
            n_out_valid             = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                cwc_pkg::CFG_INIT_PEER_WIN: n_pw   = i_cfg_data;
                cwc_pkg::CFG_SENDER_MODE:   n_mode = i_cfg_data[0];
                default:                    n_mode = r_mode;
            endcase
        end

        o_res_valid = r_out_valid;
        o_res       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw        <= cwc_pkg::START_WINDOW;
            r_uw        <= cwc_pkg::START_WINDOW;
            r_ssth      <= cwc_pkg::THRESH_RESET;
            r_gc        <= '0;
            r_pw        <= cwc_pkg::INIT_PEER_WIN;
            r_nss       <= cwc_pkg::SEQ_RESET;
            r_eack      <= cwc_pkg::EXP_ACK_RESET;
            r_inf       <= '0;
            r_zc        <= '0;
            r_lend      <= 1'b0;
            r_pend      <= 1'b0;
            r_mode      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cw        <= n_cw;
            r_uw        <= n_uw;
            r_ssth      <= n_ssth;
            r_gc        <= n_gc;
            r_pw        <= n_pw;
            r_nss       <= n_nss;
            r_eack      <= n_eack;
            r_inf       <= n_inf;
            r_zc        <= n_zc;
            r_lend      <= n_lend;
            r_pend      <= n_pend;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
`default_nettype wire

// ===== rtl/congestion_window_controller.sv =====
// A word accepted on s_axis enters the command queue; the back end pops it into the
// state update / output register. Throughput: one word per cycle while m_axis is
// not stalled; the whole window update is one back-end stage.
// Reset: synchronous, active low; windows to 1, threshold 99999999, peer window 8,
// sender mode 1, sequence 1, expected ack 2, queue and output emptied.
`default_nettype none
module congestion_window_controller (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // [31:0] ack_number, [47:32] peer_window, [48] data_ready, [49] data_is_end
    input  wire logic [cwc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] req_type
    input  wire logic [cwc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] grant, [32:1] grant_seq, [33] ack_accepted, [49:34] send_window,
    // [65:50] congestion_window, [81:66] in_flight_count
    output      logic [cwc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [cwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cwc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cwc_pkg::t_cmd    fe_cmd;
    logic             fe_push;
    logic             q_full;
    logic             be_pop;
    cwc_pkg::t_head   q_head;
    cwc_pkg::t_result be_res;

    cwc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (fe_push),
        .o_cmd         (fe_cmd)
    );

    cwc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_cmd   (fe_cmd),
        .o_full  (q_full),
        .i_pop   (be_pop),
        .o_head  (q_head)
    );

    cwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (be_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (be_res)
    );

    assign m_axis_tdata = {6'b0,
                           be_res.in_flight_count,
                           be_res.congestion_window,
                           be_res.send_window,
                           be_res.ack_accepted,
                           be_res.grant_seq,
                           be_res.grant};

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cwc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_PCT    = 7;

    typedef struct packed {
        t_req             kind;
        logic [SEQ_W-1:0] ack;
        logic [WIN_W-1:0] peer;
        logic             data_ready;
        logic             data_is_end;
    } t_evt;

    // Tracks window, credit and sequence state and holds the updates still to come out.
    class window_tracker;
        logic [WIN_W-1:0]    cwnd, usable, growth, peer_held, in_flight, cfg_peer;
        logic [THRESH_W-1:0] ssthresh;
        logic [SEQ_W-1:0]    next_seq, exp_ack;
        logic [ZCNT_W-1:0]   zero_acks;
        logic                local_done, peer_done, cfg_sender;
        t_result             expected_updates[$];
        int unsigned         mismatches, results_seen, grants_seen, acks_taken;

        function new();
            cwnd         = START_WINDOW;
            usable       = START_WINDOW;
            growth       = '0;
            cfg_peer     = INIT_PEER_WIN;
            peer_held    = INIT_PEER_WIN;
            in_flight    = '0;
            ssthresh     = THRESH_RESET;
            next_seq     = SEQ_RESET;
            exp_ack      = EXP_ACK_RESET;
            zero_acks    = '0;
            local_done   = 1'b0;
            peer_done    = 1'b0;
            cfg_sender   = 1'b1;
            mismatches   = 0;
            results_seen = 0;
            grants_seen  = 0;
            acks_taken   = 0;
        endfunction

        function void write_cfg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_INIT_PEER_WIN) begin
                cfg_peer  = val;
                peer_held = val;
            end else begin
                cfg_sender = val[0];
            end
        endfunction

        function int unsigned pending();
            return expected_updates.size();
        endfunction

        function void refresh();
            usable = (peer_held < cwnd) ? peer_held : cwnd;
        endfunction

        function void grow(input bit have_peer, input logic [WIN_W-1:0] peer);
            if (THRESH_W'(usable) > ssthresh) begin
                // congestion avoidance: one step per window's worth
                if (growth != GROWTH_MAX) growth++;
                if (growth >= usable) begin
                    if (cwnd != WINDOW_MAX) cwnd++;
                    growth = '0;
                end
            end else begin
                if (cwnd != WINDOW_MAX) cwnd++;
                if (have_peer) peer_held = peer;
            end
            refresh();
        endfunction

        function void try_send(input logic rdy, input logic is_end, inout t_result r);
            if (!local_done && in_flight < usable && rdy) begin
                r.grant     = 1'b1;
                r.grant_seq = next_seq;
                if (is_end) local_done = 1'b1;
                next_seq++;
                if (in_flight != INFLIGHT_MAX) in_flight++;
            end
        endfunction

        function void note_event(input t_evt e);
            t_result r;
            r = '0;
            case (e.kind)
                REQ_ACK: begin
                    if (e.ack == exp_ack) begin
                        r.ack_accepted = 1'b1;
                        acks_taken++;
                        if (cfg_sender) grow(1'b1, e.peer);
                        exp_ack = e.ack + 1'b1;
                        if (in_flight != 0) in_flight--;
                        try_send(e.data_ready, e.data_is_end, r);
                        zero_acks = '0;
                    end
                    // an ack of zero can also match a wrapped expected ack
                    if (e.ack == '0) begin
                        zero_acks = zero_acks + 1'b1;
                        if (zero_acks == ZERO_ACK_LIMIT) begin
                            cwnd      = cwnd >> 1;
                            zero_acks = '0;
                            ssthresh  = ssthresh >> 1;
                        end
                        refresh();
                    end
                end
                REQ_TIMEOUT: begin
                    ssthresh = ssthresh >> 1;
                    grow(1'b0, '0);
                end
                REQ_SEND: try_send(e.data_ready, e.data_is_end, r);
                REQ_PEER_END: begin
                    if (!peer_done) begin
                        peer_done = 1'b1;
                        if (cfg_sender) begin
                            grow(1'b0, '0);
                            if (cwnd != 0) cwnd--;
                            if (usable != 0) usable--;
                        end
                    end
                end
                default: ;
            endcase
            r.send_window       = usable;
            r.congestion_window = cwnd;
            r.in_flight_count   = in_flight;
            if (r.grant) grants_seen++;
            expected_updates.push_back(r);
        endfunction

        function void compare_field(input string tag, input logic [SEQ_W-1:0] want_v,
                                    input logic [SEQ_W-1:0] got_v);
            if (want_v !== got_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, tag, want_v, got_v);
            end
        endfunction

        function void check_word(input logic [M_TDATA_W-1:0] w);
            t_result want;
            results_seen++;
            if (expected_updates.size() == 0) begin
                mismatches++;
                $display("%0t: result word %0h with nothing expected, expected none, actual %0h",
                         $time, w, w);
            end else begin
                want = expected_updates.pop_front();
                compare_field("grant", SEQ_W'(want.grant), SEQ_W'(w[0]));
                compare_field("grant_seq", want.grant_seq, w[32:1]);
                compare_field("ack_accepted", SEQ_W'(want.ack_accepted), SEQ_W'(w[33]));
                compare_field("send_window", SEQ_W'(want.send_window), SEQ_W'(w[49:34]));
                compare_field("congestion_window", SEQ_W'(want.congestion_window),
                              SEQ_W'(w[65:50]));
                compare_field("in_flight_count", SEQ_W'(want.in_flight_count),
                              SEQ_W'(w[81:66]));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    window_tracker tracker;
    bit            calm;
    bit            hold_req;
    int unsigned   zero_burst;
    int unsigned   items_sent;
    int unsigned   cfg_writes;
    int unsigned   cycles;

    congestion_window_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: run stopped after %0d cycles", $time, cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            tracker.check_word(m_axis_tdata);
        end
    end

    function automatic t_evt mk(input t_req kind, input logic [SEQ_W-1:0] ack,
                                input logic [WIN_W-1:0] peer, input logic rdy,
                                input logic is_end);
        t_evt e;
        e.kind        = kind;
        e.ack         = ack;
        e.peer        = peer;
        e.data_ready  = rdy;
        e.data_is_end = is_end;
        return e;
    endfunction

    function automatic t_evt make_event(input bit end_ok);
        t_evt        e;
        int unsigned pick;
        pick          = $urandom_range(99);
        e.kind        = REQ_SEND;
        e.ack         = $urandom();
        e.peer        = 16'($urandom_range(65535));
        e.data_ready  = ($urandom_range(99) < 80);
        e.data_is_end = ($urandom_range(99) < 15);
        if (zero_burst != 0) begin
            zero_burst--;
            e.kind = REQ_ACK;
            e.ack  = '0;
        end else if (pick < 38) begin
            e.kind = REQ_ACK;
            e.ack  = tracker.exp_ack;
            case ($urandom_range(9))
                0:       e.peer = '0;
                1:       e.peer = WINDOW_MAX;
                2, 3:    ;
                default: e.peer = 16'($urandom_range(1, 64));
            endcase
        end else if (pick < 45) begin
            e.kind = REQ_ACK;
            if ($urandom_range(1) == 0) begin
                e.ack = $urandom_range(1) ? tracker.exp_ack + 1'b1 : tracker.exp_ack - 1'b1;
            end
        end else if (pick < 55) begin
            e.kind = REQ_ACK;
            e.ack  = '0;
            if ($urandom_range(99) < 30) zero_burst = 2;
        end else if (pick < 58) begin
            e.kind = REQ_TIMEOUT;
        end else if (pick < 60) begin
            e.kind = REQ_PEER_END;
        end
        // a granted end marker stops all grants, so keep it for the closing stretch
        if (!end_ok && e.data_ready) e.data_is_end = 1'b0;
        return e;
    endfunction

    task automatic push_event(input t_evt e);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - 50){1'b0}}, e.data_is_end, e.data_ready, e.peer, e.ack};
        s_axis_tuser  <= e.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_event(e);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_cfg(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_run(input int count, input bit end_ok, input int hold_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_req = 1'b1;
            push_event(make_event(end_ok));
        end
    endtask

    initial begin
        tracker       = new();
        calm          = 1'b0;
        hold_req      = 1'b0;
        zero_burst    = 0;
        items_sent    = 0;
        cfg_writes    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on reset settings
        push_event(mk(REQ_SEND, '0, '0, 1'b1, 1'b0));
        push_event(mk(REQ_SEND, '1, '1, 1'b1, 1'b0));
        push_event(mk(REQ_ACK, tracker.exp_ack, WINDOW_MAX, 1'b1, 1'b0));
        push_event(mk(REQ_ACK, '1, '0, 1'b1, 1'b1));
        push_event(mk(REQ_ACK, '0, 16'd5, 1'b1, 1'b0));
        push_event(mk(REQ_ACK, tracker.exp_ack, 16'd3, 1'b1, 1'b0));
        repeat (3) push_event(mk(REQ_ACK, '0, '1, 1'b0, 1'b0));
        push_event(mk(REQ_TIMEOUT, '1, '1, 1'b1, 1'b1));
        push_event(mk(REQ_SEND, '0, '0, 1'b0, 1'b1));
        push_event(mk(REQ_PEER_END, '0, '0, 1'b0, 1'b0));
        push_event(mk(REQ_PEER_END, '1, '1, 1'b1, 1'b0));
        push_event(mk(REQ_ACK, tracker.exp_ack, '0, 1'b1, 1'b0));
        push_event(mk(REQ_SEND, '0, '0, 1'b1, 1'b0));
        push_event(mk(REQ_ACK, tracker.exp_ack, WINDOW_MAX, 1'b0, 1'b0));
        repeat (6) push_event(mk(REQ_ACK, '0, '0, 1'b1, 1'b0));
        push_event(mk(REQ_TIMEOUT, '0, '0, 1'b0, 1'b0));
        push_event(mk(REQ_SEND, '0, '0, 1'b1, 1'b0));
        push_event(mk(REQ_ACK, tracker.exp_ack, 16'd40, 1'b1, 1'b0));
        drain_results();

        cfg_write(CFG_INIT_PEER_WIN, WINDOW_MAX);
        cfg_write(CFG_SENDER_MODE, 16'd1);
        random_run(300, 1'b0, 200);
        drain_results();
        random_run(220, 1'b0, -1);
        drain_results();

        // receiver role, small peer window, no idling on either side
        cfg_write(CFG_INIT_PEER_WIN, 16'd1);
        cfg_write(CFG_SENDER_MODE, 16'd0);
        calm = 1'b1;
        random_run(320, 1'b0, -1);
        drain_results();
        calm = 1'b0;

        cfg_write(CFG_INIT_PEER_WIN, 16'($urandom_range(2, 64)));
        cfg_write(CFG_SENDER_MODE, 16'd1);
        random_run(460, 1'b0, -1);
        drain_results();

        cfg_write(CFG_INIT_PEER_WIN, 16'd300);
        cfg_write(CFG_SENDER_MODE, 16'd1);
        random_run(150, 1'b0, -1);
        random_run(150, 1'b1, -1);
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d event words, %0d result words, %0d config writes",
                 items_sent, tracker.results_seen, cfg_writes);
        $display("  %0d grants, %0d in-order acks, final cwnd %0d, threshold %0d",
                 tracker.grants_seen, tracker.acks_taken, tracker.cwnd, tracker.ssthresh);
        if (tracker.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
